@@ design/msr_pkg.sv @@
// msr_pkg: shared types and codes for the matrix scan reorder block
// payload structs, function codes, register indexes and scan mode codes
// no dependencies
package msr_pkg;

  // configuration port
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 5;

  typedef logic [CfgIndexW-1:0] cfg_index_t;
  localparam cfg_index_t CfgMatrixSize = 2'd0;
  localparam cfg_index_t CfgScanMode   = 2'd1;

  // scan mode codes; the unused code behaves as the column snake
  typedef logic [1:0] scan_mode_t;
  localparam scan_mode_t ModeSnake  = 2'd0;
  localparam scan_mode_t ModeZigzag = 2'd1;
  localparam scan_mode_t ModeFlip   = 2'd2;

  // request function codes
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncFetch = 1'b1;

  // request and response payloads
  typedef struct packed {
    logic               func;
    logic signed [31:0] element_value;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               end_of_matrix;
  } rsp_item_t;

  // per-cycle control from the top level to the scan sequencer
  typedef struct packed {
    logic restart;
    logic load;
    logic fetch;
  } scan_ctrl_t;

endpackage

@@ design/msr_store.sv @@
// msr_store: element memory of the matrix scan reorder block
// one write port, one read port with registered read data
// depends on nothing but its parameters
module msr_store #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AddrW-1:0]    wr_addr,
  input  logic signed [31:0]  wr_data,
  input  logic                rd_en,
  input  logic [AddrW-1:0]    rd_addr,
  output logic signed [31:0]  rd_data
);

  logic signed [31:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/msr_scan.sv @@
// msr_scan: address sequencer of the matrix scan reorder block
// tracks load position, readout row/column and zigzag diagonal state
// depends on msr_pkg
module msr_scan import msr_pkg::*; #(
  parameter int MAX_SIDE = 16,
  localparam int CoordW = $clog2(MAX_SIDE),
  localparam int SideW  = $clog2(MAX_SIDE + 1),
  localparam int AddrW  = $clog2(MAX_SIDE * MAX_SIDE)
) (
  input  logic             clk,
  input  logic             rst,
  input  scan_ctrl_t       ctrl,
  input  logic [SideW-1:0] side,
  input  scan_mode_t       mode,
  output logic [AddrW-1:0] wr_addr,
  output logic [AddrW-1:0] rd_addr,
  output logic             last
);

  localparam int TotW = $clog2(MAX_SIDE * MAX_SIDE + 1);

  logic [AddrW-1:0]  load_pos, load_pos_next;
  logic [CoordW-1:0] emit_row, emit_row_next;
  logic [CoordW-1:0] emit_col, emit_col_next;
  logic [CoordW-1:0] zig_row, zig_row_next;
  logic [CoordW-1:0] zig_col, zig_col_next;
  logic [CoordW-1:0] zig_diag, zig_diag_next;
  logic              zig_second, zig_second_next;

  logic [CoordW-1:0] n_m1;
  logic [TotW-1:0]   total;
  logic              load_wrap;
  logic              emit_last;
  logic              up, up_n, step_ok;
  logic [CoordW-1:0] adv_row, adv_col, adv_diag;
  logic              adv_second;
  logic [CoordW-1:0] src_row, src_col;

  assign n_m1      = CoordW'(side - SideW'(1));
  assign total     = TotW'(side) * TotW'(side);
  assign load_wrap = (TotW'(load_pos) + TotW'(1)) >= total;
  assign emit_last = (emit_row == n_m1) && (emit_col == n_m1);
  assign last      = emit_last;
  assign wr_addr   = load_pos;

  // zigzag step along a diagonal, or onto the start of the next one
  always_comb begin
    up      = zig_second ? zig_diag[0] : !zig_diag[0];
    step_ok = up ? (zig_row != '0 && zig_col != n_m1)
                 : (zig_row != n_m1 && zig_col != '0);
    adv_row    = zig_row;
    adv_col    = zig_col;
    adv_diag   = zig_diag;
    adv_second = zig_second;
    up_n       = 1'b0;
    if (step_ok) begin
      adv_row = up ? zig_row - CoordW'(1) : zig_row + CoordW'(1);
      adv_col = up ? zig_col + CoordW'(1) : zig_col - CoordW'(1);
    end else begin
      if (zig_diag != n_m1) begin
        adv_diag = zig_diag + CoordW'(1);
      end else if (!zig_second && side > SideW'(1)) begin
        adv_second = 1'b1;
        adv_diag   = CoordW'(1);
      end else begin
        adv_second = 1'b0;
        adv_diag   = '0;
      end
      up_n = adv_second ? adv_diag[0] : !adv_diag[0];
      if (!adv_second) begin
        adv_row = up_n ? adv_diag : '0;
        adv_col = up_n ? '0 : adv_diag;
      end else begin
        adv_row = up_n ? n_m1 : adv_diag;
        adv_col = up_n ? adv_diag : n_m1;
      end
    end
  end

  // source coordinate of the current readout element
  always_comb begin
    if (mode == ModeZigzag) begin
      src_row = zig_row;
      src_col = zig_col;
    end else if (mode == ModeFlip) begin
      src_row = emit_col[0] ? n_m1 - emit_row : emit_row;
      src_col = emit_col;
    end else begin
      src_row = emit_row[0] ? n_m1 - emit_col : emit_col;
      src_col = emit_row;
    end
    rd_addr = AddrW'(src_row) * AddrW'(side) + AddrW'(src_col);
  end

  // next position state
  always_comb begin
    load_pos_next   = load_pos;
    emit_row_next   = emit_row;
    emit_col_next   = emit_col;
    zig_row_next    = zig_row;
    zig_col_next    = zig_col;
    zig_diag_next   = zig_diag;
    zig_second_next = zig_second;
    if (ctrl.restart) begin
      load_pos_next   = '0;
      emit_row_next   = '0;
      emit_col_next   = '0;
      zig_row_next    = '0;
      zig_col_next    = '0;
      zig_diag_next   = '0;
      zig_second_next = 1'b0;
    end else begin
      if (ctrl.load) begin
        load_pos_next = load_wrap ? '0 : load_pos + AddrW'(1);
      end
      if (ctrl.fetch) begin
        if (emit_last) begin
          emit_row_next   = '0;
          emit_col_next   = '0;
          zig_row_next    = '0;
          zig_col_next    = '0;
          zig_diag_next   = '0;
          zig_second_next = 1'b0;
        end else begin
          if (emit_col == n_m1) begin
            emit_col_next = '0;
            emit_row_next = emit_row + CoordW'(1);
          end else begin
            emit_col_next = emit_col + CoordW'(1);
          end
          if (mode == ModeZigzag) begin
            zig_row_next    = adv_row;
            zig_col_next    = adv_col;
            zig_diag_next   = adv_diag;
            zig_second_next = adv_second;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos   <= '0;
      emit_row   <= '0;
      emit_col   <= '0;
      zig_row    <= '0;
      zig_col    <= '0;
      zig_diag   <= '0;
      zig_second <= 1'b0;
    end else begin
      load_pos   <= load_pos_next;
      emit_row   <= emit_row_next;
      emit_col   <= emit_col_next;
      zig_row    <= zig_row_next;
      zig_col    <= zig_col_next;
      zig_diag   <= zig_diag_next;
      zig_second <= zig_second_next;
    end
  end

endmodule

@@ design/matrix_scan_reorder.sv @@
// matrix_scan_reorder: top level, configuration registers and response pipeline
// instantiates msr_scan and msr_store; depends on msr_pkg
//
// usage:
// - request channel (req_valid/req_stall/req): func load writes the next
//   element in row-major order, func fetch reads the next element of the
//   reordered matrix; a load gives no response, a fetch gives exactly one
// - response channel (rsp_valid/rsp_stall/rsp): out_value plus
//   end_of_matrix on the last element of each N*N readout
// - config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets
//   the side length, index 1 the scan mode; any write of these restarts
//   all positions, the stored elements stay; cfg_ready is always high
// - throughput: one request per cycle while req_stall is low; a fetch reaches
//   rsp through the address from the sequencer, the memory read register
//   and the response register
// - when rsp_stall holds a full response register, one more fetch can sit
//   in the memory read stage; req_stall then rises until it moves on
// - reset clears positions, pipeline valids and restores side 8, zigzag;
//   memory contents are undefined until loaded
module matrix_scan_reorder import msr_pkg::*; #(
  parameter int MAX_SIDE = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_item_t  req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_item_t  rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int SideW = $clog2(MAX_SIDE + 1);
  localparam int AddrW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int Depth = MAX_SIDE * MAX_SIDE;
  localparam logic [SideW-1:0] SideReset = SideW'((8 > MAX_SIDE) ? MAX_SIDE : 8);

  logic [SideW-1:0] side, side_next;
  scan_mode_t       mode, mode_next;
  logic             cfg_write;

  logic             p_valid;
  logic             p_last;
  logic             advance;
  logic             accept;
  scan_ctrl_t       ctrl;

  logic [AddrW-1:0]   wr_addr;
  logic [AddrW-1:0]   rd_addr;
  logic               scan_last;
  logic signed [31:0] rd_data;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    side_next = side;
    mode_next = mode;
    if (cfg_write && cfg_index == CfgMatrixSize) begin
      if (cfg_data == '0) begin
        side_next = SideW'(1);
      end else if (32'(cfg_data) > 32'(MAX_SIDE)) begin
        side_next = SideW'(MAX_SIDE);
      end else begin
        side_next = SideW'(cfg_data);
      end
    end
    if (cfg_write && cfg_index == CfgScanMode) begin
      mode_next = scan_mode_t'(cfg_data[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= SideReset;
      mode <= ModeZigzag;
    end else begin
      side <= side_next;
      mode <= mode_next;
    end
  end

  // request transfer and sequencer control
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = p_valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    ctrl.restart = cfg_write &&
                   (cfg_index == CfgMatrixSize || cfg_index == CfgScanMode);
    ctrl.load    = accept && req.func == FuncLoad;
    ctrl.fetch   = accept && req.func == FuncFetch;
  end

  msr_scan #(
    .MAX_SIDE(MAX_SIDE)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .side    (side),
    .mode    (mode),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .last    (scan_last)
  );

  msr_store #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_store (
    .clk     (clk),
    .wr_en   (ctrl.load),
    .wr_addr (wr_addr),
    .wr_data (req.element_value),
    .rd_en   (ctrl.fetch),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // memory read stage and response register valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      p_valid <= ctrl.fetch || (p_valid && !advance);
      if (advance) begin
        rsp_valid <= p_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.fetch) begin
      p_last <= scan_last;
    end
    if (advance && p_valid) begin
      rsp.out_value     <= rd_data;
      rsp.end_of_matrix <= p_last;
    end
  end

endmodule

@@ tb/matrix_scan_reorder_tb.sv @@
// matrix_scan_reorder_tb: self-checking testbench for the matrix scan reorder block
// fills the whole store, then runs directed and random load/fetch phases under all scan
// modes and sizes with random valid gaps and response stalls; depends on msr_pkg
module matrix_scan_reorder_tb;
  import msr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSide     = 16;
  localparam int HalfPeriod  = 6;
  localparam int ResetCycles = 12;
  localparam int RandomItems = 950;
  localparam int SettleCycles = 4;
  localparam int CycleLimit  = 400000;

  // register indexes the block does not decode, and the unused scan mode code
  localparam cfg_index_t CfgUnusedLo = 2'd2;
  localparam cfg_index_t CfgUnusedHi = 2'd3;
  localparam scan_mode_t ModeUnused  = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       req_valid = 1'b0;
  logic       req_stall;
  req_item_t  req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_item_t  rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  matrix_scan_reorder #(.MAX_SIDE(MaxSide)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HalfPeriod clk = ~clk;

  // shadow copy of the block state
  logic [31:0]   model_store [MaxSide*MaxSide];
  logic [4:0]    model_size = 5'd8;
  scan_mode_t    model_mode = ModeZigzag;
  logic [7:0]    load_pos = '0;
  logic [7:0]    emit_pos = '0;
  logic [3:0]    zz_row = '0;
  logic [3:0]    zz_col = '0;
  logic [4:0]    zz_diag = '0;
  logic          zz_lower = 1'b0;

  req_item_t pending_req [$];
  rsp_item_t expected_rsp [$];
  rsp_item_t want_rsp;

  int  fail_count = 0;
  int  pushed_items = 0;
  int  load_count = 0;
  int  fetch_checked = 0;
  int  reg_writes = 0;
  int  phase_count = 0;
  int  cycle_count = 0;
  int  req_gap = 0;
  int  rsp_wait = 0;
  bit  quiet = 1'b0;

  function automatic int unsigned side_length();
    if (model_size == 0) return 1;
    if (model_size > MaxSide) return MaxSide;
    return 32'(model_size);
  endfunction

  function automatic void restart_positions();
    load_pos = '0;
    emit_pos = '0;
    zz_row = '0;
    zz_col = '0;
    zz_diag = '0;
    zz_lower = 1'b0;
  endfunction

  function automatic void apply_register(cfg_index_t idx, logic [CfgDataW-1:0] data);
    if (idx == CfgMatrixSize) begin
      model_size = data;
      restart_positions();
    end else if (idx == CfgScanMode) begin
      model_mode = data[1:0];
      restart_positions();
    end
  endfunction

  // upward diagonals: even ones in the upper-left half, odd ones in the lower-right
  function automatic bit zz_up();
    return zz_lower ? zz_diag[0] : !zz_diag[0];
  endfunction

  function automatic void zz_start(int unsigned n);
    bit up;
    up = zz_up();
    if (!zz_lower) begin
      zz_row = up ? zz_diag[3:0] : 4'd0;
      zz_col = up ? 4'd0 : zz_diag[3:0];
    end else begin
      zz_row = up ? 4'(n - 1) : zz_diag[3:0];
      zz_col = up ? zz_diag[3:0] : 4'(n - 1);
    end
  endfunction

  function automatic void zz_advance(int unsigned n);
    if (zz_up()) begin
      if (zz_row > 0 && zz_col < n - 1) begin
        zz_row--;
        zz_col++;
        return;
      end
    end else if (zz_row < n - 1 && zz_col > 0) begin
      zz_row++;
      zz_col--;
      return;
    end
    // step to the next diagonal, switching halves at the main one
    if (zz_diag < n - 1) begin
      zz_diag++;
    end else if (!zz_lower && n > 1) begin
      zz_lower = 1'b1;
      zz_diag = 5'd1;
    end else begin
      zz_diag = '0;
      zz_lower = 1'b0;
    end
    zz_start(n);
  endfunction

  // update the shadow state for one accepted request, queue the response it causes
  function automatic void reorder_step(req_item_t item);
    int unsigned n, total, r, c, src_row, src_col, addr;
    bit last;
    rsp_item_t exp_item;
    n = side_length();
    total = n * n;
    if (item.func == FuncLoad) begin
      model_store[load_pos] = item.element_value;
      load_pos = (32'(load_pos) + 1 < total) ? load_pos + 8'd1 : 8'd0;
      load_count++;
      return;
    end
    r = emit_pos / n;
    c = emit_pos % n;
    if (model_mode == ModeZigzag) begin
      src_row = 32'(zz_row);
      src_col = 32'(zz_col);
    end else if (model_mode == ModeFlip) begin
      src_row = c[0] ? n - 1 - r : r;
      src_col = c;
    end else begin
      src_row = r[0] ? n - 1 - c : c;
      src_col = r;
    end
    addr = src_row * n + src_col;
    exp_item.out_value = model_store[addr[7:0]];
    last = (32'(emit_pos) + 1 >= total);
    exp_item.end_of_matrix = last;
    if (last) begin
      emit_pos = '0;
      zz_row = '0;
      zz_col = '0;
      zz_diag = '0;
      zz_lower = 1'b0;
    end else begin
      emit_pos++;
      if (model_mode == ModeZigzag) zz_advance(n);
    end
    expected_rsp = {expected_rsp, exp_item};
  endfunction

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // mostly small sides, a few large ones and the out-of-range codes
  function automatic logic [4:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 5'($urandom_range(1, 5));
    if (roll < 80) return 5'($urandom_range(6, 10));
    if (roll < 88) return 5'($urandom_range(11, 16));
    if (roll < 94) return 5'd0;
    return 5'($urandom_range(17, 31));
  endfunction

  function automatic scan_mode_t pick_mode();
    case ($urandom_range(0, 3))
      0: return ModeSnake;
      1: return ModeZigzag;
      2: return ModeFlip;
      default: return ModeUnused;
    endcase
  endfunction

  function automatic void push_item(logic func, logic [31:0] value);
    req_item_t item;
    item.func = func;
    item.element_value = value;
    pending_req = {pending_req, item};
    pushed_items++;
  endfunction

  // register write over the config channel, taken into the shadow state on transfer
  task automatic cfg_write(cfg_index_t idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, data);
    reg_writes++;
    @(negedge clk);
  endtask

  // hold the sender until every queued request went out and every response came back
  task automatic drain();
    do @(negedge clk); while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        reorder_step(req);
        req_gap = draw_wait();
      end
      if (!(req_valid && req_stall)) begin
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (pending_req.size() > 0) begin
          req <= pending_req.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and stall generator
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("unexpected response: out_value %0d end_of_matrix %0b",
                 rsp.out_value, rsp.end_of_matrix);
          fail_count++;
        end else begin
          want_rsp = expected_rsp.pop_front();
          fetch_checked++;
          if (rsp.out_value !== want_rsp.out_value) begin
            $error("out_value mismatch: expected %0d, got %0d",
                   want_rsp.out_value, rsp.out_value);
            fail_count++;
          end
          if (rsp.end_of_matrix !== want_rsp.end_of_matrix) begin
            $error("end_of_matrix mismatch: expected %0b, got %0b",
                   want_rsp.end_of_matrix, rsp.end_of_matrix);
            fail_count++;
          end
        end
        rsp_wait = draw_wait();
      end
      if (rsp_wait > 0) begin
        rsp_stall <= 1'b1;
        rsp_wait--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int unsigned n, total, reps, kind, sel, k;
    int random_start;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // write every store entry once so no fetch ever reads an unwritten one
    cfg_write(CfgMatrixSize, 5'd16);
    for (int i = 0; i < MaxSide * MaxSide; i++) push_item(FuncLoad, pick_element());
    for (int i = 0; i < MaxSide * MaxSide; i++) push_item(FuncFetch, '0);
    drain();

    // single element matrix, readout wraps right away
    cfg_write(CfgMatrixSize, 5'd1);
    push_item(FuncLoad, 32'h7FFF_FFFF);
    push_item(FuncFetch, '0);
    push_item(FuncFetch, '0);
    drain();
    // side 0 behaves as side 1
    cfg_write(CfgMatrixSize, 5'd0);
    push_item(FuncLoad, 32'h8000_0000);
    push_item(FuncFetch, '0);
    drain();
    // oversized side clamps, ignored index, fetch before any load
    cfg_write(CfgMatrixSize, 5'd31);
    cfg_write(CfgUnusedHi, 5'd31);
    push_item(FuncFetch, '0);
    push_item(FuncFetch, 32'hFFFF_FFFF);
    drain();
    // unused mode acts as column snake; sender paused before readout
    cfg_write(CfgMatrixSize, 5'd2);
    cfg_write(CfgScanMode, CfgDataW'(ModeUnused));
    push_item(FuncLoad, 32'h0000_0000);
    push_item(FuncLoad, 32'hFFFF_FFFF);
    push_item(FuncLoad, 32'h8000_0000);
    push_item(FuncLoad, 32'h7FFF_FFFF);
    drain();
    for (int i = 0; i < 4; i++) push_item(FuncFetch, '0);
    drain();
    // odd-column flip with a load in the middle of the readout
    cfg_write(CfgScanMode, CfgDataW'(ModeFlip));
    push_item(FuncFetch, '0);
    push_item(FuncFetch, '0);
    push_item(FuncLoad, 32'h1234_5678);
    push_item(FuncFetch, '0);
    push_item(FuncFetch, '0);
    drain();

    // random phases
    random_start = pushed_items;
    while (pushed_items - random_start < RandomItems) begin
      phase_count++;
      quiet = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 3);
      if (sel != 1) cfg_write(CfgMatrixSize, pick_size());
      if (sel != 2) cfg_write(CfgScanMode, CfgDataW'(pick_mode()));
      if (sel == 3) cfg_write($urandom_range(0, 1) ? CfgUnusedLo : CfgUnusedHi,
                              CfgDataW'($urandom_range(0, 31)));
      n = side_length();
      total = n * n;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // full load then one or two complete readouts
        reps = ($urandom_range(0, 3) == 0) ? 2 : 1;
        for (int i = 0; i < total; i++) push_item(FuncLoad, pick_element());
        if ($urandom_range(0, 3) == 0) drain();
        for (int i = 0; i < total * reps; i++) push_item(FuncFetch, $urandom());
      end else if (kind == 7) begin
        // full load then loads and fetches mixed
        for (int i = 0; i < total; i++) push_item(FuncLoad, pick_element());
        for (int i = 0; i < 2 * total; i++)
          push_item($urandom_range(0, 1) ? FuncFetch : FuncLoad, pick_element());
      end else if (kind == 8) begin
        // readout of old contents with occasional loads
        for (int i = 0; i < total; i++)
          push_item(($urandom_range(0, 3) == 0) ? FuncLoad : FuncFetch, pick_element());
      end else begin
        // broken sequence: partial load, partial readout
        k = $urandom_range(1, total);
        for (int i = 0; i < k; i++) push_item(FuncLoad, pick_element());
        k = $urandom_range(1, total);
        for (int i = 0; i < k; i++) push_item(FuncFetch, $urandom());
      end
      drain();
    end

    quiet = 1'b0;
    drain();
    repeat (2 * SettleCycles) @(posedge clk);
    $display("covered %0d loads and %0d checked fetches over %0d random phases",
             load_count, fetch_checked, phase_count);
    $display("with %0d register writes across sides 0..31 and all four scan mode codes",
             reg_writes);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/msr_pkg.sv
design/msr_store.sv
design/msr_scan.sv
design/matrix_scan_reorder.sv
tb/matrix_scan_reorder_tb.sv
